[hw/rtl/dual_frequency_gnss_combination_defines.svh]
// assertion macros for the dual frequency combination block
`ifndef DUAL_FREQUENCY_GNSS_COMBINATION_DEFINES_SVH
`define DUAL_FREQUENCY_GNSS_COMBINATION_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define DFGC_ASSERT_NOW(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dfgc check failed");

// next-cycle implication, sampled on clock, off during reset
`define DFGC_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dfgc check failed");

`endif

[hw/rtl/dfgc_pkg.sv]
// shared widths, codes and types of the dual frequency combination block
package dfgc_pkg;

   localparam int PW    = 41;
   localparam int FW    = 31;
   localparam int RW    = 37;
   localparam int TW    = 10;
   localparam int OW    = 46;
   localparam int MAGW  = 42;
   localparam int COEFW = 96;
   localparam int PRODW = 128;
   localparam int DW    = 88;
   localparam int QW    = 47;
   localparam int NPROD = 8;

   localparam logic [28:0] C_LIGHT   = 29'd299792458;
   localparam logic [23:0] TGD_SCALE = 24'd9765625;

   localparam logic [QW-1:0] OUT_POS_LIM = 47'h1FFF_FFFF_FFFF;
   localparam logic [QW-1:0] OUT_NEG_LIM = 47'h2000_0000_0000;

   localparam logic CMD_GENERAL = 1'b0;
   localparam logic CMD_BDS     = 1'b1;

   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_FREQ = 2'd1;
   localparam logic [1:0] STAT_SAT  = 2'd2;

   typedef struct packed {
      logic          cmd;
      logic          err;
      logic [DW-1:0] d0;
      logic [DW-1:0] d1;
      logic [DW-1:0] d2;
      logic          sg0;
      logic          sg1;
      logic          sg2;
   } side_type;

   typedef struct packed {
      logic [NPROD-1:0][COEFW-1:0] coef;
      logic [NPROD-1:0][MAGW-1:0]  mag;
      logic [NPROD-1:0]            neg;
      side_type                    side;
   } front_type;

   typedef struct packed {
      logic neg;
      logic cmd;
      logic err;
   } tag_type;

endpackage

[hw/rtl/dfgc_front.sv]
// front stages: signs, magnitudes, coefficients and divisors of each word
module dfgc_front
   import dfgc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic                 in_command,
   input  logic signed [PW-1:0] in_phase_first,
   input  logic signed [PW-1:0] in_phase_second,
   input  logic [FW-1:0]        in_freq_first,
   input  logic [FW-1:0]        in_freq_second,
   input  logic signed [RW-1:0] in_range_first,
   input  logic signed [RW-1:0] in_range_second,
   input  logic signed [TW-1:0] in_group_delay,
   output logic                 out_valid,
   output front_type            out_data
);

   typedef struct packed {
      logic            cmd;
      logic            err;
      logic            dfneg;
      logic            dpneg;
      logic [MAGW-1:0] dpmag;
      logic            p1neg;
      logic [PW-1:0]   p1mag;
      logic            p2neg;
      logic [PW-1:0]   p2mag;
      logic            r1neg;
      logic [RW-1:0]   r1mag;
      logic            r2neg;
      logic [RW-1:0]   r2mag;
      logic            tneg;
   } pass_type;

   typedef struct packed {
      pass_type      ps;
      logic [FW-1:0] adf;
      logic [FW:0]   sf;
      logic [FW-1:0] f1;
      logic [FW-1:0] f2;
      logic [TW-1:0] tmag;
   } s1_type;

   typedef struct packed {
      logic [60:0] ksf;
      logic [61:0] k1;
      logic [61:0] k2;
      logic [59:0] kf1;
      logic [59:0] kf2;
      logic [61:0] g1;
      logic [61:0] g2;
      logic [62:0] dd0;
      logic [61:0] dd1;
      logic [38:0] ct;
   } prod_type;

   typedef struct packed {
      pass_type ps;
      prod_type pr;
   } s2_type;

   typedef struct packed {
      pass_type    ps;
      prod_type    pr;
      logic [61:0] dsq;
      logic        dneg;
   } s3_type;

   typedef struct packed {
      pass_type    ps;
      prod_type    pr;
      logic [61:0] dsq;
      logic        dneg;
      logic [54:0] dq_lo;
      logic [54:0] dq_hi;
      logic [54:0] g1_lo;
      logic [54:0] g1_hi;
      logic [54:0] g2_lo;
      logic [54:0] g2_hi;
   } s4_type;

   s1_type    s1_in, s1_ff;
   s2_type    s2_in, s2_ff;
   s3_type    s3_in, s3_ff;
   s4_type    s4_in, s4_ff;
   front_type s5_in, s5_ff;
   logic [4:0] valid_ff;

   logic [MAGW-1:0] dp;
   logic [PW-1:0]   p1u, p2u;
   logic [RW-1:0]   r1u, r2u;
   logic [TW-1:0]   tu;
   logic [85:0]     dsqt, h1, h2;

   // stage 1: differences and magnitudes
   always_comb begin
      p1u = in_phase_first;
      p2u = in_phase_second;
      r1u = in_range_first;
      r2u = in_range_second;
      tu  = in_group_delay;
      dp  = {p1u[PW-1], p1u} - {p2u[PW-1], p2u};
      s1_in.ps.cmd   = in_command;
      s1_in.ps.err   = (in_freq_first == in_freq_second) || (in_freq_first == '0) ||
                       (in_freq_second == '0);
      s1_in.ps.dfneg = in_freq_first < in_freq_second;
      s1_in.ps.dpneg = dp[MAGW-1];
      s1_in.ps.dpmag = dp[MAGW-1] ? -dp : dp;
      s1_in.ps.p1neg = p1u[PW-1];
      s1_in.ps.p1mag = p1u[PW-1] ? -p1u : p1u;
      s1_in.ps.p2neg = p2u[PW-1];
      s1_in.ps.p2mag = p2u[PW-1] ? -p2u : p2u;
      s1_in.ps.r1neg = r1u[RW-1];
      s1_in.ps.r1mag = r1u[RW-1] ? -r1u : r1u;
      s1_in.ps.r2neg = r2u[RW-1];
      s1_in.ps.r2mag = r2u[RW-1] ? -r2u : r2u;
      s1_in.ps.tneg  = tu[TW-1];
      s1_in.tmag     = tu[TW-1] ? -tu : tu;
      s1_in.adf      = s1_in.ps.dfneg ? in_freq_second - in_freq_first :
                                        in_freq_first - in_freq_second;
      s1_in.sf       = {1'b0, in_freq_first} + {1'b0, in_freq_second};
      s1_in.f1       = in_freq_first;
      s1_in.f2       = in_freq_second;
   end

   // stage 2: first level products
   always_comb begin
      s2_in.ps     = s1_ff.ps;
      s2_in.pr.ksf = 61'(C_LIGHT) * 61'(s1_ff.sf);
      s2_in.pr.k1  = 62'(s1_ff.adf) * 62'(s1_ff.f1);
      s2_in.pr.k2  = 62'(s1_ff.adf) * 62'(s1_ff.f2);
      s2_in.pr.kf1 = 60'(C_LIGHT) * 60'(s1_ff.f1);
      s2_in.pr.kf2 = 60'(C_LIGHT) * 60'(s1_ff.f2);
      s2_in.pr.g1  = 62'(s1_ff.f1) * 62'(s1_ff.f1);
      s2_in.pr.g2  = 62'(s1_ff.f2) * 62'(s1_ff.f2);
      s2_in.pr.dd0 = 63'(s1_ff.adf) * 63'(s1_ff.sf);
      s2_in.pr.dd1 = 62'(s1_ff.f1) * 62'(s1_ff.f2);
      s2_in.pr.ct  = 39'(C_LIGHT) * 39'(s1_ff.tmag);
   end

   // stage 3: difference of the squared frequencies
   always_comb begin
      s3_in.ps   = s2_ff.ps;
      s3_in.pr   = s2_ff.pr;
      s3_in.dneg = s2_ff.pr.g1 < s2_ff.pr.g2;
      s3_in.dsq  = s3_in.dneg ? s2_ff.pr.g2 - s2_ff.pr.g1 : s2_ff.pr.g1 - s2_ff.pr.g2;
   end

   // stage 4: partial products with the group delay scale
   always_comb begin
      s4_in.ps    = s3_ff.ps;
      s4_in.pr    = s3_ff.pr;
      s4_in.dsq   = s3_ff.dsq;
      s4_in.dneg  = s3_ff.dneg;
      s4_in.dq_lo = 55'(s3_ff.dsq[30:0]) * 55'(TGD_SCALE);
      s4_in.dq_hi = 55'(s3_ff.dsq[61:31]) * 55'(TGD_SCALE);
      s4_in.g1_lo = 55'(s3_ff.pr.g1[30:0]) * 55'(TGD_SCALE);
      s4_in.g1_hi = 55'(s3_ff.pr.g1[61:31]) * 55'(TGD_SCALE);
      s4_in.g2_lo = 55'(s3_ff.pr.g2[30:0]) * 55'(TGD_SCALE);
      s4_in.g2_hi = 55'(s3_ff.pr.g2[61:31]) * 55'(TGD_SCALE);
   end

   // stage 5: operand selection per command
   always_comb begin
      dsqt = 86'(s4_ff.dq_lo) + {s4_ff.dq_hi, 31'b0};
      h1   = 86'(s4_ff.g1_lo) + {s4_ff.g1_hi, 31'b0};
      h2   = 86'(s4_ff.g2_lo) + {s4_ff.g2_hi, 31'b0};
      s5_in.coef[0] = COEFW'(s4_ff.pr.ksf);
      s5_in.mag[0]  = s4_ff.ps.dpmag;
      s5_in.neg[0]  = s4_ff.ps.dpneg;
      s5_in.coef[1] = COEFW'({s4_ff.pr.k1, 2'b0});
      s5_in.mag[1]  = MAGW'(s4_ff.ps.r1mag);
      s5_in.neg[1]  = s4_ff.ps.dfneg == s4_ff.ps.r1neg;
      s5_in.coef[2] = COEFW'({s4_ff.pr.k2, 2'b0});
      s5_in.mag[2]  = MAGW'(s4_ff.ps.r2mag);
      s5_in.neg[2]  = s4_ff.ps.dfneg == s4_ff.ps.r2neg;
      s5_in.coef[3] = COEFW'(s4_ff.pr.kf2);
      s5_in.mag[3]  = MAGW'(s4_ff.ps.p1mag);
      s5_in.neg[3]  = s4_ff.ps.p1neg;
      s5_in.coef[4] = COEFW'(s4_ff.pr.kf1);
      s5_in.mag[4]  = MAGW'(s4_ff.ps.p2mag);
      s5_in.neg[4]  = !s4_ff.ps.p2neg;
      s5_in.mag[5]  = MAGW'(s4_ff.ps.r1mag);
      s5_in.mag[6]  = MAGW'(s4_ff.ps.r2mag);
      if (s4_ff.ps.cmd == CMD_BDS) begin
         s5_in.coef[5] = COEFW'(h1);
         s5_in.neg[5]  = !s4_ff.ps.r1neg;
         s5_in.coef[6] = COEFW'(h2);
         s5_in.neg[6]  = s4_ff.ps.r2neg;
         s5_in.coef[7] = COEFW'(s4_ff.pr.g1);
         s5_in.mag[7]  = MAGW'(s4_ff.pr.ct);
         s5_in.neg[7]  = s4_ff.ps.tneg;
         s5_in.side.d2  = DW'(dsqt);
         s5_in.side.sg2 = !s4_ff.dneg;
      end else begin
         s5_in.coef[5] = COEFW'(s4_ff.pr.g1);
         s5_in.neg[5]  = s4_ff.ps.r1neg;
         s5_in.coef[6] = COEFW'(s4_ff.pr.g2);
         s5_in.neg[6]  = !s4_ff.ps.r2neg;
         s5_in.coef[7] = '0;
         s5_in.mag[7]  = '0;
         s5_in.neg[7]  = 1'b0;
         s5_in.side.d2  = DW'(s4_ff.dsq);
         s5_in.side.sg2 = s4_ff.dneg;
      end
      s5_in.side.cmd = s4_ff.ps.cmd;
      s5_in.side.err = s4_ff.ps.err;
      s5_in.side.d0  = DW'({s4_ff.pr.dd0, 2'b0});
      s5_in.side.d1  = DW'({s4_ff.pr.dd1, 2'b0});
      s5_in.side.sg0 = s4_ff.ps.dfneg;
      s5_in.side.sg1 = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
      end
   end

   assign out_valid = valid_ff[4];
   assign out_data  = s5_ff;

endmodule

[hw/rtl/dfgc_mul.sv]
// two stage wide multiplier built from 32 bit partial products
module dfgc_mul
   import dfgc_pkg::*;
(
   input  logic             clock,
   input  logic             en,
   input  logic [COEFW-1:0] coef,
   input  logic [MAGW-1:0]  mag,
   output logic [PRODW-1:0] prod
);

   logic [2:0][63:0] pl_in, pl_ff;
   logic [2:0][41:0] ph_in, ph_ff;
   logic [PRODW-1:0] prod_in, prod_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pl_in[i] = 64'(coef[32*i +: 32]) * 64'(mag[31:0]);
         ph_in[i] = 42'(coef[32*i +: 32]) * 42'(mag[MAGW-1:32]);
      end
      prod_in = PRODW'(pl_ff[0]) + (PRODW'(ph_ff[0]) << 32) +
                (PRODW'(pl_ff[1]) << 32) + (PRODW'(ph_ff[1]) << 64) +
                (PRODW'(pl_ff[2]) << 64) + (PRODW'(ph_ff[2]) << 96);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pl_ff   <= pl_in;
         ph_ff   <= ph_in;
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

[hw/rtl/dfgc_div.sv]
// pipelined restoring divider, one quotient bit per stage, with overflow check
module dfgc_div
   import dfgc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [PRODW-1:0] in_a,
   input  logic [DW-1:0]    in_b,
   input  tag_type          in_tag,
   output logic             out_valid,
   output logic [QW-1:0]    out_q,
   output logic             out_sat,
   output tag_type          out_tag
);

   localparam int CW = DW + QW;

   logic [QW:0]      valid_ff;
   logic [PRODW-1:0] rem_ff [0:QW];
   logic [DW-1:0]    b_ff   [0:QW];
   logic [QW-1:0]    q_ff   [0:QW];
   logic             sat_ff [0:QW];
   tag_type          tag_ff [0:QW];

   // quotient must fit in QW bits, else the result saturates
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= in_a;
         b_ff[0]   <= in_b;
         q_ff[0]   <= '0;
         sat_ff[0] <= CW'(in_a) >= {in_b, QW'(0)};
         tag_ff[0] <= in_tag;
      end
   end

   for (genvar k = 1; k <= QW; k++) begin : g_step
      logic [CW-1:0]    sh;
      logic             ge;
      logic [PRODW-1:0] rem_in;
      logic [QW-1:0]    q_in;

      always_comb begin
         sh     = CW'(b_ff[k-1]) << (QW - k);
         ge     = CW'(rem_ff[k-1]) >= sh;
         rem_in = ge ? PRODW'(CW'(rem_ff[k-1]) - sh) : rem_ff[k-1];
         q_in   = q_ff[k-1];
         q_in[QW-k] = ge;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            b_ff[k]   <= b_ff[k-1];
            q_ff[k]   <= q_in;
            sat_ff[k] <= sat_ff[k-1];
            tag_ff[k] <= tag_ff[k-1];
         end
      end
   end

   assign out_valid = valid_ff[QW];
   assign out_q     = q_ff[QW];
   assign out_sat   = sat_ff[QW];
   assign out_tag   = tag_ff[QW];

endmodule

[hw/rtl/dual_frequency_gnss_combination.sv]
// top level: dual frequency combinations, ionosphere-free and group delay forms
// throughput: one word per cycle while no result word is stalled, set by the fully pipelined quotient dividers
// a stalled result word holds the whole pipeline until it is taken
// reset (synchronous, active high) clears all valid bits; data registers keep no reset
module dual_frequency_gnss_combination
   import dfgc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_command,
   input  logic signed [PW-1:0] req_phase_first,
   input  logic signed [PW-1:0] req_phase_second,
   input  logic [FW-1:0]        req_freq_first,
   input  logic [FW-1:0]        req_freq_second,
   input  logic signed [RW-1:0] req_range_first,
   input  logic signed [RW-1:0] req_range_second,
   input  logic signed [TW-1:0] req_group_delay,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic signed [OW-1:0] rsp_wide_lane_comb,
   output logic signed [OW-1:0] rsp_geometry_free,
   output logic signed [OW-1:0] rsp_iono_free,
   output logic [1:0]           rsp_status
);

   localparam int NW = PRODW + 2;

   typedef struct packed {
      side_type         side;
      logic [NPROD-1:0] neg;
   } mside_type;

   typedef struct packed {
      logic [OW-1:0] val;
      logic          over;
   } fix_type;

   function automatic fix_type fix_lane(input logic [QW-1:0] q, input logic sat,
                                        input logic neg_pre);
      logic          neg;
      logic          over;
      logic [QW-1:0] lim;
      logic [QW-1:0] mag;
      logic [QW-1:0] mneg;
      fix_type       r;
      neg    = neg_pre && (sat || (q != '0));
      lim    = neg ? OUT_NEG_LIM : OUT_POS_LIM;
      over   = sat || (q > lim);
      mag    = over ? lim : q;
      mneg   = -mag;
      r.val  = neg ? mneg[OW-1:0] : mag[OW-1:0];
      r.over = over;
      return r;
   endfunction

   logic      en;
   logic      fr_valid;
   front_type fr;

   logic [NPROD-1:0][PRODW-1:0] prod;

   logic      m1_valid_ff, m2_valid_ff;
   mside_type m1_ff, m2_ff;

   logic [NPROD-1:0][NW-1:0] term;
   logic [2:0][NW-1:0]       n_in, n_ff;
   logic                     s8_valid_ff;
   side_type                 s8_side_ff;

   logic [2:0][NW-1:0]    nmag;
   logic [2:0][PRODW-1:0] a_in, a_ff;
   logic [2:0][DW-1:0]    d_sel, b_ff;
   logic [2:0]            sg_sel;
   tag_type [2:0]         tag_in, tag_ff;
   logic                  s9_valid_ff;

   logic [2:0]         dv_valid;
   logic [2:0][QW-1:0] dv_q;
   logic [2:0]         dv_sat;
   tag_type [2:0]      dv_tag;

   fix_type [2:0] fx;
   logic          o_cmd, o_err, o_sat;

   logic          rsp_valid_ff;
   logic [OW-1:0] wide_ff, wide_in, geo_ff, geo_in, iono_ff, iono_in;
   logic [1:0]    status_ff, status_in;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   dfgc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .en              (en),
      .in_valid        (req_valid),
      .in_command      (req_command),
      .in_phase_first  (req_phase_first),
      .in_phase_second (req_phase_second),
      .in_freq_first   (req_freq_first),
      .in_freq_second  (req_freq_second),
      .in_range_first  (req_range_first),
      .in_range_second (req_range_second),
      .in_group_delay  (req_group_delay),
      .out_valid       (fr_valid),
      .out_data        (fr)
   );

   for (genvar k = 0; k < NPROD; k++) begin : g_mul
      dfgc_mul u_mul (
         .clock (clock),
         .en    (en),
         .coef  (fr.coef[k]),
         .mag   (fr.mag[k]),
         .prod  (prod[k])
      );
   end

   // lane sums: wide lane, geometry free, ionosphere free
   always_comb begin
      for (int k = 0; k < NPROD; k++) begin
         term[k] = m2_ff.neg[k] ? -NW'(prod[k]) : NW'(prod[k]);
      end
      n_in[0] = term[0] + term[1] + term[2];
      n_in[1] = term[3] + term[4];
      n_in[2] = term[5] + term[6] + term[7];
   end

   // dividend 2|n| + d over divisor 2d gives the rounded quotient
   always_comb begin
      d_sel[0]  = s8_side_ff.d0;
      d_sel[1]  = s8_side_ff.d1;
      d_sel[2]  = s8_side_ff.d2;
      sg_sel[0] = s8_side_ff.sg0;
      sg_sel[1] = s8_side_ff.sg1;
      sg_sel[2] = s8_side_ff.sg2;
      for (int l = 0; l < 3; l++) begin
         nmag[l]       = n_ff[l][NW-1] ? -n_ff[l] : n_ff[l];
         a_in[l]       = {nmag[l][PRODW-2:0], 1'b0} + PRODW'(d_sel[l]);
         tag_in[l].neg = n_ff[l][NW-1] ^ sg_sel[l];
         tag_in[l].cmd = s8_side_ff.cmd;
         tag_in[l].err = s8_side_ff.err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
         s8_valid_ff <= 1'b0;
         s9_valid_ff <= 1'b0;
      end else if (en) begin
         m1_valid_ff <= fr_valid;
         m2_valid_ff <= m1_valid_ff;
         s8_valid_ff <= m2_valid_ff;
         s9_valid_ff <= s8_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_ff.side <= fr.side;
         m1_ff.neg  <= fr.neg;
         m2_ff      <= m1_ff;
         n_ff       <= n_in;
         s8_side_ff <= m2_ff.side;
         a_ff       <= a_in;
         for (int l = 0; l < 3; l++) begin
            b_ff[l] <= {d_sel[l][DW-2:0], 1'b0};
         end
         tag_ff     <= tag_in;
      end
   end

   for (genvar l = 0; l < 3; l++) begin : g_div
      dfgc_div u_div (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (s9_valid_ff),
         .in_a      (a_ff[l]),
         .in_b      (b_ff[l]),
         .in_tag    (tag_ff[l]),
         .out_valid (dv_valid[l]),
         .out_q     (dv_q[l]),
         .out_sat   (dv_sat[l]),
         .out_tag   (dv_tag[l])
      );
   end

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         fx[l] = fix_lane(dv_q[l], dv_sat[l], dv_tag[l].neg);
      end
      o_cmd = dv_tag[0].cmd | dv_tag[1].cmd | dv_tag[2].cmd;
      o_err = dv_tag[0].err | dv_tag[1].err | dv_tag[2].err;
      o_sat = (o_cmd == CMD_BDS) ? fx[2].over : (fx[0].over | fx[1].over | fx[2].over);
      if (o_err) begin
         wide_in   = '0;
         geo_in    = '0;
         iono_in   = '0;
         status_in = STAT_FREQ;
      end else begin
         wide_in   = (o_cmd == CMD_BDS) ? '0 : fx[0].val;
         geo_in    = (o_cmd == CMD_BDS) ? '0 : fx[1].val;
         iono_in   = fx[2].val;
         status_in = o_sat ? STAT_SAT : STAT_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= &dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wide_ff   <= wide_in;
         geo_ff    <= geo_in;
         iono_ff   <= iono_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_wide_lane_comb = wide_ff;
   assign rsp_geometry_free  = geo_ff;
   assign rsp_iono_free      = iono_ff;
   assign rsp_status         = status_ff;

endmodule

[hw/rtl/dfgc_checker.sv]
// port level checks of the combination block and their bind to the top level
`include "dual_frequency_gnss_combination_defines.svh"

module dfgc_checker
   import dfgc_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 req_command,
   input logic signed [PW-1:0] req_phase_first,
   input logic signed [PW-1:0] req_phase_second,
   input logic [FW-1:0]        req_freq_first,
   input logic [FW-1:0]        req_freq_second,
   input logic signed [RW-1:0] req_range_first,
   input logic signed [RW-1:0] req_range_second,
   input logic signed [TW-1:0] req_group_delay,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic signed [OW-1:0] rsp_wide_lane_comb,
   input logic signed [OW-1:0] rsp_geometry_free,
   input logic signed [OW-1:0] rsp_iono_free,
   input logic [1:0]           rsp_status
);

   `DFGC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_iono_free) && $stable(rsp_status))
   `DFGC_ASSERT_NOW(a_freq_zero, rsp_valid && rsp_status == STAT_FREQ, rsp_wide_lane_comb == '0 && rsp_geometry_free == '0 && rsp_iono_free == '0)
   `DFGC_ASSERT_NOW(a_status_code, rsp_valid, rsp_status == STAT_OK || rsp_status == STAT_FREQ || rsp_status == STAT_SAT)
   `DFGC_ASSERT_NOW(a_ready_free, !rsp_valid, req_ready)

endmodule

bind dual_frequency_gnss_combination dfgc_checker u_dfgc_checker (.*);
